FILE: rtl/bmhq_pkg.sv
// Shared types and codes of the binary max-heap priority queue.
package bmhq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ROW_W  = 2 * DATA_W;

  typedef logic signed [DATA_W-1:0] data_t;

  // Sift request handed from one level cell to the next.
  typedef struct packed {
    logic             valid;
    logic             active;
    data_t            value;
    logic [ROW_W-1:0] row;
  } tok_t;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

FILE: rtl/bmhq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bmhq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bmhq_cell.sv
// One heap level: its storage, the child-row read for the level below and one sift step.
module bmhq_cell import bmhq_pkg::*; #(
  parameter int unsigned LEVEL      = 0,
  parameter int unsigned NUM_LEVELS = 8,
  parameter int unsigned CNT_W      = 8,
  localparam int unsigned LocW = NUM_LEVELS - 1,
  localparam int unsigned LvlW = $clog2(NUM_LEVELS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_t             tok_i,
  input  logic [LocW-1:0]  pos_i,
  input  logic             is_ext_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [LvlW-1:0]  tgt_lvl_i,
  input  logic [LocW-1:0]  tgt_loc_i,
  input  logic             rd_en_i,
  input  logic [LocW-1:0]  rd_row_i,
  output logic [ROW_W-1:0] rd_data_o,
  output logic             nxt_rd_en_o,
  output logic [LocW-1:0]  nxt_rd_row_o,
  input  logic [ROW_W-1:0] nxt_rd_data_i,
  output tok_t             tok_o,
  output logic [LocW-1:0]  pos_o
);

  localparam int unsigned Rows    = (LEVEL == 0) ? 1 : (1 << (LEVEL - 1));
  localparam int unsigned AddrW   = (Rows > 1) ? $clog2(Rows) : 1;
  localparam bit          HasNext = (LEVEL + 1 < NUM_LEVELS);
  localparam int unsigned IdxW    = LocW + 3;
  localparam logic [IdxW-1:0] ChildBase = IdxW'((1 << (LEVEL + 1)) - 1);

  tok_t            cur_q;
  logic [LocW-1:0] cur_pos_q;
  tok_t            tok_q;
  logic [LocW-1:0] pos_q;

  data_t           own_val;
  data_t           left_val;
  data_t           right_val;
  data_t           kid_val;
  data_t           wr_val;
  data_t           nxt_value;
  logic [IdxW-1:0] left_idx;
  logic [IdxW-1:0] right_idx;
  logic            left_ok;
  logic            right_ok;
  logic            pick_right;
  logic [LvlW-1:0] shift;
  logic            nxt_active;
  logic [LocW-1:0] nxt_pos;
  logic            wr_en;
  logic [ROW_W-1:0] wr_row;
  logic [LocW-1:0] own_row;

  bmhq_ram #(
    .WIDTH(ROW_W),
    .DEPTH(Rows)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(own_row[AddrW-1:0]),
    .wdata_i(wr_row),
    .re_i   (rd_en_i),
    .raddr_i(rd_row_i[AddrW-1:0]),
    .rdata_o(rd_data_o)
  );

  assign nxt_rd_en_o  = HasNext && tok_i.valid && tok_i.active;
  assign nxt_rd_row_o = pos_i;

  assign own_row   = cur_pos_q >> 1;
  assign own_val   = cur_pos_q[0] ? cur_q.row[ROW_W-1:DATA_W] : cur_q.row[DATA_W-1:0];
  assign left_val  = nxt_rd_data_i[DATA_W-1:0];
  assign right_val = nxt_rd_data_i[ROW_W-1:DATA_W];

  assign left_idx   = ChildBase + IdxW'({cur_pos_q, 1'b0});
  assign right_idx  = left_idx + IdxW'(1);
  assign left_ok    = HasNext && (left_idx < IdxW'(count_i));
  assign right_ok   = HasNext && (right_idx < IdxW'(count_i));
  assign pick_right = right_ok && (right_val > left_val);
  assign kid_val    = pick_right ? right_val : left_val;
  assign shift      = tgt_lvl_i - LvlW'(LEVEL + 1);

  always_comb begin
    wr_val     = cur_q.value;
    nxt_value  = cur_q.value;
    nxt_active = 1'b0;
    nxt_pos    = '0;
    if (is_ext_i) begin
      if (left_ok && (kid_val > cur_q.value)) begin
        wr_val     = kid_val;
        nxt_active = 1'b1;
        nxt_pos    = LocW'({cur_pos_q, pick_right});
      end
    end else if (tgt_lvl_i != LvlW'(LEVEL)) begin
      nxt_active = 1'b1;
      nxt_pos    = tgt_loc_i >> shift;
      if (cur_q.value > own_val) begin
        nxt_value = own_val;
      end else begin
        wr_val = own_val;
      end
    end
  end

  assign wr_en  = cur_q.valid && cur_q.active;
  assign wr_row = cur_pos_q[0] ? {wr_val, cur_q.row[DATA_W-1:0]}
                               : {cur_q.row[ROW_W-1:DATA_W], wr_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      tok_q <= '0;
    end else begin
      cur_q        <= tok_i;
      tok_q.valid  <= cur_q.valid;
      tok_q.active <= cur_q.active && nxt_active;
      tok_q.value  <= nxt_value;
      tok_q.row    <= nxt_rd_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_pos_q <= pos_i;
    pos_q     <= nxt_pos;
  end

  assign tok_o = tok_q;
  assign pos_o = pos_q;

endmodule

FILE: rtl/binary_max_heap_queue_core.sv
// Top level of the binary max-heap priority queue: control, occupancy tracking and the level chain.
// Each request either inserts a signed 32-bit value or removes and returns the largest one.
// The heap is kept one level per cell, L = ceil(log2(HEAP_DEPTH + 1)) cells, each with its own
// RAM holding sibling pairs; a sift travels down the chain, and at each level the registered
// read of the child row is followed by the compare and write. An extract that leaves the heap
// empty needs no sift, and a rejected request (insert into a full heap, extract from an empty
// one) goes straight to the completion state without a fetch or a sift.
// One request is in progress at a time; a new request is taken as soon as the previous result
// has moved into the output register, which waits while an unaccepted result is still held there.
// The occupancy field reports the low eight bits of the count.
module binary_max_heap_queue_core import bmhq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic signed [31:0] operand_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] max_value_o,
  output logic [1:0]         status_o,
  output logic [7:0]         occupancy_o
);

  localparam int unsigned NumLevels = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned LocW      = NumLevels - 1;
  localparam int unsigned LvlW      = $clog2(NumLevels + 1);
  localparam int unsigned CntW      = $clog2(HEAP_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_SIFT   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [LvlW-1:0] tail_lvl_q, tail_lvl_d;
  logic [LocW-1:0] tail_loc_q, tail_loc_d;
  logic [LvlW-1:0] op_lvl_q, op_lvl_d;
  logic [LocW-1:0] op_loc_q, op_loc_d;
  logic            is_ext_q, is_ext_d;
  data_t           op_val_q, op_val_d;
  data_t           res_max_q, res_max_d;
  logic [1:0]      res_status_q, res_status_d;
  tok_t            launch_q, launch_d;
  logic            out_valid_q, out_valid_d;
  data_t           out_max_q, out_max_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [7:0]      out_occ_q, out_occ_d;

  logic [LvlW-1:0] inc_lvl, dec_lvl;
  logic [LocW-1:0] inc_loc, dec_loc;
  logic [ROW_W-1:0] tail_row;
  data_t           tail_val;

  tok_t             tok_in  [NumLevels];
  tok_t             tok_out [NumLevels];
  logic [LocW-1:0]  pos_in  [NumLevels];
  logic [LocW-1:0]  pos_out [NumLevels];
  logic             lvl_rd_en  [NumLevels];
  logic [LocW-1:0]  lvl_rd_row [NumLevels];
  logic [ROW_W-1:0] lvl_rd_data [NumLevels];
  logic             nxt_en  [NumLevels];
  logic [LocW-1:0]  nxt_row [NumLevels];

  function automatic logic [LocW-1:0] lvl_mask(input logic [LvlW-1:0] lvl);
    logic [LocW:0] m;
    m = ({{LocW{1'b0}}, 1'b1} << lvl) - {{LocW{1'b0}}, 1'b1};
    return m[LocW-1:0];
  endfunction

  always_comb begin
    if (tail_loc_q == lvl_mask(tail_lvl_q)) begin
      inc_lvl = tail_lvl_q + LvlW'(1);
      inc_loc = '0;
    end else begin
      inc_lvl = tail_lvl_q;
      inc_loc = tail_loc_q + LocW'(1);
    end
    if (tail_loc_q == '0) begin
      dec_lvl = tail_lvl_q - LvlW'(1);
      dec_loc = lvl_mask(tail_lvl_q - LvlW'(1));
    end else begin
      dec_lvl = tail_lvl_q;
      dec_loc = tail_loc_q - LocW'(1);
    end
  end

  always_comb begin
    tail_row = '0;
    for (int k = 0; k < NumLevels; k++) begin
      if (op_lvl_q == LvlW'(k)) begin
        tail_row = lvl_rd_data[k];
      end
    end
  end

  assign tail_val = op_loc_q[0] ? tail_row[ROW_W-1:DATA_W] : tail_row[DATA_W-1:0];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    tail_lvl_d   = tail_lvl_q;
    tail_loc_d   = tail_loc_q;
    op_lvl_d     = op_lvl_q;
    op_loc_d     = op_loc_q;
    is_ext_d     = is_ext_q;
    op_val_d     = op_val_q;
    res_max_d    = res_max_q;
    res_status_d = res_status_q;
    launch_d     = '0;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_max_d    = out_max_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          is_ext_d     = opcode_i;
          op_val_d     = operand_value_i;
          res_max_d    = '0;
          res_status_d = STATUS_OK;
          if (opcode_i == OP_INSERT) begin
            if (count_q == CntW'(HEAP_DEPTH)) begin
              res_status_d = STATUS_FULL;
              state_d      = S_DONE;
            end else begin
              count_d    = count_q + CntW'(1);
              op_lvl_d   = tail_lvl_q;
              op_loc_d   = tail_loc_q;
              tail_lvl_d = inc_lvl;
              tail_loc_d = inc_loc;
              state_d    = S_FETCH;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = STATUS_EMPTY;
              state_d      = S_DONE;
            end else begin
              count_d    = count_q - CntW'(1);
              op_lvl_d   = dec_lvl;
              op_loc_d   = dec_loc;
              tail_lvl_d = dec_lvl;
              tail_loc_d = dec_loc;
              state_d    = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        state_d = S_LAUNCH;
      end
      S_LAUNCH: begin
        launch_d.row = lvl_rd_data[0];
        if (is_ext_q) begin
          res_max_d = lvl_rd_data[0][DATA_W-1:0];
          if (count_q == '0) begin
            state_d = S_DONE;
          end else begin
            launch_d.valid  = 1'b1;
            launch_d.active = 1'b1;
            launch_d.value  = tail_val;
            state_d         = S_SIFT;
          end
        end else begin
          launch_d.valid  = 1'b1;
          launch_d.active = 1'b1;
          launch_d.value  = op_val_q;
          state_d         = S_SIFT;
        end
      end
      S_SIFT: begin
        if (tok_out[NumLevels-1].valid) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_max_d    = res_max_q;
          out_status_d = res_status_q;
          out_occ_d    = 8'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      tail_lvl_q  <= '0;
      tail_loc_q  <= '0;
      launch_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      tail_lvl_q  <= tail_lvl_d;
      tail_loc_q  <= tail_loc_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_lvl_q     <= op_lvl_d;
    op_loc_q     <= op_loc_d;
    is_ext_q     <= is_ext_d;
    op_val_q     <= op_val_d;
    res_max_q    <= res_max_d;
    res_status_q <= res_status_d;
    out_max_q    <= out_max_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  for (genvar k = 0; k < NumLevels; k++) begin : g_level
    if (k == 0) begin : g_root
      assign tok_in[k]     = launch_q;
      assign pos_in[k]     = '0;
      assign lvl_rd_en[k]  = (state_q == S_FETCH);
      assign lvl_rd_row[k] = '0;
    end else begin : g_inner
      assign tok_in[k]     = tok_out[k-1];
      assign pos_in[k]     = pos_out[k-1];
      assign lvl_rd_en[k]  = ((state_q == S_FETCH) && is_ext_q && (op_lvl_q == LvlW'(k)))
                             || nxt_en[k-1];
      assign lvl_rd_row[k] = (state_q == S_FETCH) ? (op_loc_q >> 1) : nxt_row[k-1];
    end

    logic [ROW_W-1:0] child_data;
    if (k + 1 < NumLevels) begin : g_child
      assign child_data = lvl_rd_data[k+1];
    end else begin : g_leaf
      assign child_data = '0;
    end

    bmhq_cell #(
      .LEVEL     (k),
      .NUM_LEVELS(NumLevels),
      .CNT_W     (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .tok_i        (tok_in[k]),
      .pos_i        (pos_in[k]),
      .is_ext_i     (is_ext_q),
      .count_i      (count_q),
      .tgt_lvl_i    (op_lvl_q),
      .tgt_loc_i    (op_loc_q),
      .rd_en_i      (lvl_rd_en[k]),
      .rd_row_i     (lvl_rd_row[k]),
      .rd_data_o    (lvl_rd_data[k]),
      .nxt_rd_en_o  (nxt_en[k]),
      .nxt_rd_row_o (nxt_row[k]),
      .nxt_rd_data_i(child_data),
      .tok_o        (tok_out[k]),
      .pos_o        (pos_out[k])
    );
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign max_value_o = out_max_q;
  assign status_o    = out_status_q;
  assign occupancy_o = out_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(HEAP_DEPTH))
    else $error("entry count exceeds the heap depth");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside the completion state");

  a_sift_end_in_sift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_out[NumLevels-1].valid |-> state_q == S_SIFT)
    else $error("sift left the last level while no sift was in progress");

  a_empty_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> (tail_lvl_q == '0 && tail_loc_q == '0))
    else $error("free-slot position out of step with an empty heap");

endmodule
